[rtl/rct_pkg.sv]
// rct_pkg: shared widths, action and status codes, and record/packet types
// for the reference count table. No dependencies.
package rct_pkg;

   localparam int TABLE_DEPTH = 16;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 72;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INC    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DEC    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_BYKEY  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd4;

   typedef enum logic {
      CTL_IDLE,
      CTL_SWEEP
   } ctl_state_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  count;
   } rec_type;

   localparam rec_type REC_EMPTY = '0;

   // operation broadcast to every cell
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic                push;
   } bcast_type;

   // search packet handed from cell to cell
   typedef struct packed {
      logic                live;
      logic                found;
      logic                uflow;
      logic [COUNT_W-1:0]  count;
      logic [KEY_W-1:0]    fkey;
      logic [HANDLE_W-1:0] fhandle;
   } pkt_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [COUNT_W-1:0]  count;
      logic [KEY_W-1:0]    fkey;
      logic [HANDLE_W-1:0] fhandle;
   } rsp_type;

endpackage

[rtl/rct_cell.sv]
// rct_cell: one table slot plus one stage of the search packet chain.
// Depends on rct_pkg.
module rct_cell (
   input  logic               clock,
   input  logic               reset,
   input  rct_pkg::bcast_type bcast,
   input  rct_pkg::rec_type   rec_prev,
   input  rct_pkg::rec_type   rec_next,
   input  rct_pkg::pkt_type   pkt_up,
   output rct_pkg::rec_type   rec,
   output rct_pkg::pkt_type   pkt_down
);

   rct_pkg::rec_type rec_ff, rec_in;
   rct_pkg::pkt_type pkt_down_ff, pkt_down_in;
   logic key_eq, match, hit, drop_op;

   always_comb begin
      key_eq = (rec_ff.key == bcast.key);
      unique case (bcast.action) inside
         rct_pkg::ACT_REMOVE, rct_pkg::ACT_INC, rct_pkg::ACT_DEC, rct_pkg::ACT_READ: begin
            match = key_eq;
         end
         rct_pkg::ACT_BYKEY: begin
            match = (rec_ff.handle == bcast.handle);
         end
         rct_pkg::ACT_FREE: begin
            match = key_eq && (rec_ff.count == '0);
         end
         default: begin
            match = 1'b0;
         end
      endcase
      hit = pkt_up.live && !pkt_up.found && rec_ff.valid && match;
      drop_op = (bcast.action == rct_pkg::ACT_REMOVE) || (bcast.action == rct_pkg::ACT_FREE);

      rec_in = rec_ff;
      if (bcast.push) begin
         rec_in = rec_prev;
      end else if (pkt_up.live && drop_op && (pkt_up.found || hit)) begin
         // close the gap: take the older neighbor's record
         rec_in = rec_next;
      end else if (hit && bcast.action == rct_pkg::ACT_INC && rec_ff.count != '1) begin
         rec_in.count = rec_ff.count + rct_pkg::COUNT_W'(1);
      end else if (hit && bcast.action == rct_pkg::ACT_DEC && rec_ff.count != '0) begin
         rec_in.count = rec_ff.count - rct_pkg::COUNT_W'(1);
      end

      pkt_down_in = pkt_up;
      if (hit) begin
         pkt_down_in.found = 1'b1;
         pkt_down_in.uflow = (bcast.action == rct_pkg::ACT_DEC) && (rec_ff.count == '0);
         if (bcast.action == rct_pkg::ACT_READ) begin
            pkt_down_in.count = rec_ff.count;
         end
         if (bcast.action == rct_pkg::ACT_BYKEY) begin
            pkt_down_in.fkey = rec_ff.key;
         end
         if (bcast.action == rct_pkg::ACT_FREE) begin
            pkt_down_in.fhandle = rec_ff.handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff.key      <= rec_in.key;
      rec_ff.handle   <= rec_in.handle;
      rec_ff.count    <= rec_in.count;
      pkt_down_ff.found   <= pkt_down_in.found;
      pkt_down_ff.uflow   <= pkt_down_in.uflow;
      pkt_down_ff.count   <= pkt_down_in.count;
      pkt_down_ff.fkey    <= pkt_down_in.fkey;
      pkt_down_ff.fhandle <= pkt_down_in.fhandle;
      if (reset) begin
         rec_ff.valid     <= 1'b0;
         pkt_down_ff.live <= 1'b0;
      end else begin
         rec_ff.valid     <= rec_in.valid;
         pkt_down_ff.live <= pkt_down_in.live;
      end
   end

   assign rec      = rec_ff;
   assign pkt_down = pkt_down_ff;

   // occupied slots stay a contiguous run from the front
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      rec_ff.valid |-> rec_prev.valid)
      else $error("occupied slot behind an empty one");

endmodule

[rtl/rct_ctrl.sv]
// rct_ctrl: request acceptance, operation broadcast, packet launch and
// response register for the reference count table. Depends on rct_pkg.
module rct_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rct_pkg::ACTION_W-1:0]      req_action,
   input  logic [rct_pkg::KEY_W-1:0]         req_key,
   input  logic [rct_pkg::HANDLE_W-1:0]      req_handle,
   input  logic                              table_full,
   input  rct_pkg::pkt_type                  pkt_tail,
   output rct_pkg::bcast_type                bcast,
   output rct_pkg::rec_type                  new_rec,
   output rct_pkg::pkt_type                  pkt_launch,
   output logic                              rsp_valid,
   input  logic                              rsp_tready,
   output rct_pkg::rsp_type                  rsp
);

   rct_pkg::ctl_state_type state_ff, state_in;
   logic [rct_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [rct_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [rct_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic launch_ff, launch_in;
   logic rsp_valid_ff, rsp_valid_in;
   rct_pkg::rsp_type rsp_ff, rsp_in;
   logic accept, sweep_op, push;

   always_comb begin
      req_tready = (state_ff == rct_pkg::CTL_IDLE) && (!rsp_valid_ff || rsp_tready);
      accept     = req_tvalid && req_tready;
      sweep_op   = (req_action != rct_pkg::ACT_ADD) && (req_action <= rct_pkg::ACT_FREE);
      push       = accept && (req_action == rct_pkg::ACT_ADD) && (req_handle != '0) && !table_full;

      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      handle_in    = handle_ff;
      launch_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         rct_pkg::CTL_IDLE: begin
            if (accept) begin
               act_in    = req_action;
               key_in    = req_key;
               handle_in = req_handle;
               if (sweep_op) begin
                  launch_in = 1'b1;
                  state_in  = rct_pkg::CTL_SWEEP;
               end else begin
                  // add and the unused code answer at once
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (req_action == rct_pkg::ACT_ADD) begin
                     if (req_handle == '0) begin
                        rsp_in.status = rct_pkg::STS_NULL;
                     end else if (table_full) begin
                        rsp_in.status = rct_pkg::STS_FULL;
                     end else begin
                        rsp_in.status = rct_pkg::STS_OK;
                     end
                  end
               end
            end
         end
         rct_pkg::CTL_SWEEP: begin
            if (pkt_tail.live) begin
               state_in       = rct_pkg::CTL_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_in.found   = pkt_tail.found;
               rsp_in.count   = pkt_tail.count;
               rsp_in.fkey    = pkt_tail.fkey;
               rsp_in.fhandle = pkt_tail.fhandle;
               if (!pkt_tail.found) begin
                  rsp_in.status = rct_pkg::STS_NOT_FOUND;
               end else if (pkt_tail.uflow) begin
                  rsp_in.status = rct_pkg::STS_UNDERFLOW;
               end else begin
                  rsp_in.status = rct_pkg::STS_OK;
               end
            end
         end
         default: begin
            state_in = rct_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rct_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      key_ff    <= key_in;
      handle_ff <= handle_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      bcast.action  = act_ff;
      bcast.key     = key_ff;
      bcast.handle  = handle_ff;
      bcast.push    = push;

      new_rec.valid  = 1'b1;
      new_rec.key    = req_key;
      new_rec.handle = req_handle;
      new_rec.count  = rct_pkg::COUNT_W'(1);

      pkt_launch      = '0;
      pkt_launch.live = launch_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_tail_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pkt_tail.live |-> state_ff == rct_pkg::CTL_SWEEP)
      else $error("packet left the chain outside a sweep");

   a_launch_in_sweep: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> state_ff == rct_pkg::CTL_SWEEP)
      else $error("packet launched outside a sweep");

   a_rsp_empty_in_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == rct_pkg::CTL_SWEEP |-> !rsp_valid_ff)
      else $error("response pending while a sweep runs");

endmodule

[rtl/refcount_table.sv]
// refcount_table: top level of the reference count table, a chain of slot
// cells fed by a controller. Depends on rct_pkg, rct_cell and rct_ctrl.
//
//   channel  direction  contents
//   req_*    in         action, key, handle
//   rsp_*    out        status, found, count, found_key, freed_handle
//
// add and the unused action code answer in the cycle after the transaction.
// every other action sends a search packet down the chain, one cell per
// cycle; the packet passes the launch register and every cell, and the
// response is registered as it leaves the tail. one operation is in flight at a time.
// reset empties the table at once (slot valid bits only); there is no sweep.
// a new request is taken while a response waits, as long as the response
// is taken in the same cycle; a stalled response holds its data.
module refcount_table #(
   parameter int DEPTH = rct_pkg::TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] action, [18:3] key, [50:19] handle, [55:51] zero
   input  logic [rct_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] status, [3] found, [19:4] count, [35:20] found_key,
   // [67:36] freed_handle, [71:68] zero
   output logic [rct_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int KEY_LO    = rct_pkg::ACTION_W;
   localparam int HANDLE_LO = KEY_LO + rct_pkg::KEY_W;
   localparam int RSP_USED  = rct_pkg::STATUS_W + 1 + rct_pkg::COUNT_W
                              + rct_pkg::KEY_W + rct_pkg::HANDLE_W;

   rct_pkg::bcast_type bcast;
   rct_pkg::rec_type   new_rec;
   rct_pkg::rec_type   rec [DEPTH];
   rct_pkg::pkt_type   pkt [DEPTH+1];
   rct_pkg::rsp_type   rsp;

   // request fields unpacked from tdata
   logic [rct_pkg::ACTION_W-1:0] req_action;
   logic [rct_pkg::KEY_W-1:0]    req_key;
   logic [rct_pkg::HANDLE_W-1:0] req_handle;

   assign req_action = req_tdata[rct_pkg::ACTION_W-1:0];
   assign req_key    = req_tdata[HANDLE_LO-1:KEY_LO];
   assign req_handle = req_tdata[HANDLE_LO+rct_pkg::HANDLE_W-1:HANDLE_LO];

   // controller: decodes the transaction, pushes adds, launches searches
   rct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_action),
      .req_key    (req_key),
      .req_handle (req_handle),
      .table_full (rec[DEPTH-1].valid),   // slots fill from the front
      .pkt_tail   (pkt[DEPTH]),
      .bcast      (bcast),
      .new_rec    (new_rec),
      .pkt_launch (pkt[0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // slot chain: slot 0 is the newest record; adds shift toward the tail,
   // removals pull the older records forward as the packet passes
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rct_pkg::rec_type prev_rec, next_rec;
      if (i == 0) begin : g_head
         assign prev_rec = new_rec;
      end else begin : g_body
         assign prev_rec = rec[i-1];
      end
      if (i == DEPTH-1) begin : g_tail
         assign next_rec = rct_pkg::REC_EMPTY;
      end else begin : g_inner
         assign next_rec = rec[i+1];
      end

      rct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bcast    (bcast),
         .rec_prev (prev_rec),
         .rec_next (next_rec),
         .pkt_up   (pkt[i]),
         .rec      (rec[i]),
         .pkt_down (pkt[i+1])
      );
   end

   // response packing, status in the low bits
   assign rsp_tdata = {(rct_pkg::RSP_TDATA_W - RSP_USED)'(0),
                       rsp.fhandle, rsp.fkey, rsp.count, rsp.found, rsp.status};

endmodule
